// ===== design/gsr_pkg.sv =====
// ============================================================================
// gsr_pkg - shared types and constants of the gas sensor frame responder
// Request codes, frame byte codes and the response descriptor type.
// ============================================================================
package gsr_pkg;

    // request codes carried in req_type
    typedef enum logic [1:0] {
        REQ_RX_BYTE = 2'd0,
        REQ_UPLOAD  = 2'd1,
        REQ_TIMEOUT = 2'd2,
        REQ_TX_DONE = 2'd3
    } t_req;

    // frame byte codes
    localparam logic [7:0] START_BYTE   = 8'hFF;
    localparam logic [7:0] CMD_READ     = 8'h86;
    localparam logic [7:0] CMD_SWITCH   = 8'h78;
    localparam logic [7:0] CMD_ZERO_CAL = 8'h87;
    localparam logic [7:0] CMD_SPAN_CAL = 8'h88;
    localparam logic [7:0] SUB_QUERY    = 8'h04;
    localparam logic [7:0] SUB_ACTIVE   = 8'h03;
    localparam logic [7:0] ADDR_ONE     = 8'h01;
    localparam logic [7:0] ZERO_BYTE    = 8'h00;

    // reading limit in ppm
    localparam logic signed [15:0] PPM_MAX = 16'sd100;

    // frame geometry: byte positions 0..8, position 8 holds the checksum
    localparam logic [3:0] LAST_IDX = 4'd8;
    localparam logic [3:0] POS_B1   = 4'd1;
    localparam logic [3:0] POS_B2   = 4'd2;
    localparam logic [3:0] POS_B3   = 4'd3;
    localparam logic [3:0] POS_ZERO = 4'd0;

    // default depth of the response queue
    localparam int QUEUE_DEPTH_DEF = 4;

    // response descriptor: bytes 1..3 of an outgoing frame
    typedef struct packed {
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
    } t_resp;

    // queue status seen by the front and back parts
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ===== design/gsr_in_if.sv =====
// ============================================================================
// gsr_in_if - request channel
// Valid/ready channel carrying one request beat.
// ============================================================================
interface gsr_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic [7:0]         rx_byte;
    logic signed [15:0] concentration_ppm;
    logic               reading_invalid;
    logic               warming_up;

    modport source (
        output valid, req_type, rx_byte, concentration_ppm, reading_invalid, warming_up,
        input  ready
    );
    modport sink (
        input  valid, req_type, rx_byte, concentration_ppm, reading_invalid, warming_up,
        output ready
    );
endinterface

// ===== design/gsr_out_if.sv =====
// ============================================================================
// gsr_out_if - response byte channel
// Valid/ready channel carrying one transmit byte beat.
// ============================================================================
interface gsr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       last_byte;

    modport source (
        output valid, tx_byte, last_byte,
        input  ready
    );
    modport sink (
        input  valid, tx_byte, last_byte,
        output ready
    );
endinterface

// ===== design/gsr_resp_fifo.sv =====
// ============================================================================
// gsr_resp_fifo - response descriptor queue
// Small register queue between the front and back parts.
// ============================================================================
module gsr_resp_fifo #(
    parameter int DEPTH = gsr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  gsr_pkg::t_resp    i_push_data,
    input  logic              i_pop,
    output gsr_pkg::t_resp    o_head,
    output gsr_pkg::t_q_status o_status
);
    import gsr_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_resp         r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_head         = r_mem[r_rd];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

// ===== design/gsr_front.sv =====
// ============================================================================
// gsr_front - request intake and command decode
// Gathers command frames, checks them, tracks mode and transmit busy, and
// queues one response descriptor per frame to be sent.
// ============================================================================
module gsr_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    gsr_in_if.sink             i_in,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  gsr_pkg::t_q_status i_q_status,
    output logic               o_push,
    output gsr_pkg::t_resp     o_push_data
);
    import gsr_pkg::*;

    // frame gathering state
    logic [3:0] r_count, n_count;
    logic [7:0] r_sum,   n_sum;     // running sum of bytes 1..7
    logic [7:0] r_b1,    n_b1;
    logic [7:0] r_b2,    n_b2;
    logic [7:0] r_b3,    n_b3;
    logic       r_query, n_query;
    logic       r_busy,  n_busy;
    logic       r_fault, n_fault;

    logic       accept;
    t_req       req;
    logic [7:0] rx_b;
    logic [7:0] reading;
    logic [7:0] sum_all;
    logic       want;
    t_resp      resp;

    assign i_in.ready = !i_q_status.full;
    assign accept     = i_in.valid && i_in.ready;
    assign req        = t_req'(i_in.req_type);
    assign rx_b       = i_in.rx_byte;
    assign sum_all    = r_sum + rx_b;

    // reported reading, clamped to 0..100
    always_comb begin
        if (i_in.warming_up || i_in.reading_invalid) begin
            reading = ZERO_BYTE;
        end else if (i_in.concentration_ppm < 16'sd0) begin
            reading = ZERO_BYTE;
        end else if (i_in.concentration_ppm > PPM_MAX) begin
            reading = PPM_MAX[7:0];
        end else begin
            reading = i_in.concentration_ppm[7:0];
        end
    end

    // next state and response decision
    always_comb begin
        n_count = r_count;
        n_sum   = r_sum;
        n_b1    = r_b1;
        n_b2    = r_b2;
        n_b3    = r_b3;
        n_query = r_query;
        n_busy  = r_busy;
        n_fault = r_fault;
        want    = 1'b0;
        resp    = '{b1: CMD_READ, b2: ZERO_BYTE, b3: reading};

        if (i_cfg_we) begin
            n_fault = i_cfg_wdata;
        end

        if (accept) begin
            case (req)
                REQ_RX_BYTE: begin
                    if (r_count == POS_ZERO && rx_b != START_BYTE) begin
                        // stray byte outside a frame
                        n_count = r_count;
                    end else if (r_count > LAST_IDX) begin
                        n_count = POS_ZERO;
                    end else if (r_count == LAST_IDX) begin
                        // checksum byte: frame complete
                        n_count = POS_ZERO;
                        if (sum_all == ZERO_BYTE && !r_fault) begin
                            if (r_b1 == CMD_READ) begin
                                want = 1'b1;
                            end else if (r_b1 == ADDR_ONE) begin
                                case (r_b2)
                                    CMD_READ: want = 1'b1;
                                    CMD_SWITCH: begin
                                        if (r_b3 == SUB_QUERY) begin
                                            n_query = 1'b1;
                                            want    = 1'b1;
                                        end else if (r_b3 == SUB_ACTIVE) begin
                                            n_query = 1'b0;
                                            want    = 1'b1;
                                        end
                                        resp = '{b1: CMD_SWITCH, b2: ADDR_ONE,
                                                 b3: ZERO_BYTE};
                                    end
                                    CMD_ZERO_CAL: begin
                                        want = 1'b1;
                                        resp = '{b1: CMD_ZERO_CAL, b2: ADDR_ONE,
                                                 b3: ZERO_BYTE};
                                    end
                                    CMD_SPAN_CAL: begin
                                        want = 1'b1;
                                        resp = '{b1: CMD_SPAN_CAL, b2: ADDR_ONE,
                                                 b3: ZERO_BYTE};
                                    end
                                    default: want = 1'b0;
                                endcase
                            end
                        end
                    end else begin
                        // body byte
                        n_count = r_count + 1'b1;
                        if (r_count == POS_ZERO) begin
                            n_sum = ZERO_BYTE;
                        end else begin
                            n_sum = sum_all;
                        end
                        if (r_count == POS_B1) n_b1 = rx_b;
                        if (r_count == POS_B2) n_b2 = rx_b;
                        if (r_count == POS_B3) n_b3 = rx_b;
                    end
                end
                REQ_UPLOAD: begin
                    want = !r_fault && !r_query;
                end
                REQ_TIMEOUT: begin
                    if (r_count != POS_ZERO && r_count <= LAST_IDX) begin
                        n_count = POS_ZERO;
                    end
                end
                REQ_TX_DONE: begin
                    n_busy = 1'b0;
                end
                default: n_busy = r_busy;
            endcase
        end

        // a response goes out only when the transmitter is free
        o_push      = want && !r_busy;
        o_push_data = resp;
        if (o_push) begin
            n_busy = 1'b1;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= POS_ZERO;
            r_query <= 1'b0;
            r_busy  <= 1'b0;
            r_fault <= 1'b0;
        end else begin
            r_count <= n_count;
            r_query <= n_query;
            r_busy  <= n_busy;
            r_fault <= n_fault;
        end
    end

    // frame payload
    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
        r_b1  <= n_b1;
        r_b2  <= n_b2;
        r_b3  <= n_b3;
    end

endmodule

// ===== design/gsr_back.sv =====
// ============================================================================
// gsr_back - response frame serializer
// Takes response descriptors from the queue and sends each as 9 byte beats.
// ============================================================================
module gsr_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gsr_pkg::t_resp     i_head,
    input  gsr_pkg::t_q_status i_q_status,
    output logic               o_pop,
    gsr_out_if.source          o_out
);
    import gsr_pkg::*;

    logic       r_active, n_active;
    logic [3:0] r_idx,    n_idx;
    t_resp      r_desc,   n_desc;
    logic [7:0] r_chk,    n_chk;

    logic       beat;
    logic       last;

    assign last            = (r_idx == LAST_IDX);
    assign beat            = o_out.valid && o_out.ready;
    assign o_out.valid     = r_active;
    assign o_out.last_byte = last;

    // byte select for the current position
    always_comb begin
        case (r_idx)
            POS_ZERO: o_out.tx_byte = START_BYTE;
            POS_B1:   o_out.tx_byte = r_desc.b1;
            POS_B2:   o_out.tx_byte = r_desc.b2;
            POS_B3:   o_out.tx_byte = r_desc.b3;
            LAST_IDX: o_out.tx_byte = r_chk;
            default:  o_out.tx_byte = ZERO_BYTE;
        endcase
    end

    // advance and reload from the queue
    always_comb begin
        n_active = r_active;
        n_idx    = r_idx;
        n_desc   = r_desc;
        n_chk    = r_chk;
        o_pop    = 1'b0;
        if (!r_active || (beat && last)) begin
            n_active = !i_q_status.empty;
            if (!i_q_status.empty) begin
                o_pop  = 1'b1;
                n_idx  = POS_ZERO;
                n_desc = i_head;
                n_chk  = ZERO_BYTE - (i_head.b1 + i_head.b2 + i_head.b3);
            end
        end else if (beat) begin
            n_idx = r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_idx    <= POS_ZERO;
        end else begin
            r_active <= n_active;
            r_idx    <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_desc <= n_desc;
        r_chk  <= n_chk;
    end

endmodule

// ===== design/gas_sensor_uart_frame_responder.sv =====
// ============================================================================
// gas_sensor_uart_frame_responder - sensor command frame responder
// Gathers 9-byte command frames and answers with 9-byte response frames.
// ============================================================================
//  channel   dir  handshake        payload
//  i_in      in   valid / ready    req_type, rx_byte, concentration_ppm,
//                                  reading_invalid, warming_up
//  o_out     out  valid / ready    tx_byte, last_byte
//  cfg       in   i_cfg_we         i_cfg_wdata (fault_active)
//
//  One request beat per cycle. The first byte of a response is valid on o_out
//  once its descriptor has passed through the response queue and has been
//  loaded into the serializer. A frame takes 9 byte beats, and frames follow
//  back to back while the sink is ready. Reset is synchronous and clears all
//  control state. The front stalls only when the response queue is full; the
//  byte serializer drains it independently of incoming requests.
// ============================================================================
module gas_sensor_uart_frame_responder #(
    parameter int QUEUE_DEPTH = gsr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gsr_in_if.sink    i_in,
    gsr_out_if.source o_out,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata
);
    import gsr_pkg::*;

    logic      push;
    t_resp     push_data;
    logic      pop;
    t_resp     head;
    t_q_status q_status;

    gsr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_push_data (push_data)
    );

    gsr_resp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head      (head),
        .o_status    (q_status)
    );

    gsr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_out      (o_out)
    );

endmodule

// ===== tb/sv/gas_sensor_uart_frame_responder_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// gas_sensor_uart_frame_responder_test - self-checking bench of the responder
// Drives request beats (received bytes, upload ticks, receive timeouts and
// transmit-done events) through the request channel. A behavioral predictor
// queues the response bytes each accepted beat should cause, and a checker
// compares every response beat against the oldest queued byte. Directed
// checks come first, then fault-register traffic, randomized frame traffic
// under several idle mixes, and a long receiver stall that fills the block.
// ============================================================================
module gas_sensor_uart_frame_responder_test;
    import gsr_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int FRAME_LEN    = 9;

    // byte i of a frame sits at index i
    typedef logic [FRAME_LEN-1:0][7:0] t_frame;

    typedef struct {
        t_req               req;
        logic [7:0]         rx;
        logic signed [15:0] ppm;
        logic               inv;
        logic               warm;
    } t_request;

    typedef struct {
        logic [7:0] tx;
        logic       last;
    } t_tx_beat;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    gsr_in_if  in_if ();
    gsr_out_if out_if ();

    gas_sensor_uart_frame_responder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // predictor state
    logic       fault_on;
    t_frame     cmd_buf;
    logic [3:0] cmd_count;
    logic       query_on;
    logic       tx_busy;
    t_tx_beat   tx_bytes_due[$];

    int   errors        = 0;
    int   req_beats     = 0;
    int   tx_beats      = 0;
    int   cycle_count   = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic hold_go       = 1'b0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    // negated sum of bytes 1..7, modulo 256
    function automatic logic [7:0] frame_checksum(input t_frame f);
        logic [7:0] acc;
        acc = '0;
        for (int i = 1; i <= 7; i++) acc += f[i];
        return 8'h00 - acc;
    endfunction

    // reading reported on the wire: 0 on warmup or invalid, else clamped
    function automatic logic [15:0] reported_ppm(input t_request r);
        if (r.warm || r.inv) return 16'h0000;
        if (r.ppm < 16'sd0) return 16'h0000;
        if (r.ppm > PPM_MAX) return PPM_MAX;
        return r.ppm;
    endfunction

    task automatic queue_frame(input logic [7:0] b1, input logic [7:0] b2,
                               input logic [7:0] b3);
        t_frame f;
        if (tx_busy) return;
        tx_busy = 1'b1;
        f = '0;
        f[0] = START_BYTE;
        f[1] = b1;
        f[2] = b2;
        f[3] = b3;
        f[8] = frame_checksum(f);
        for (int i = 0; i < FRAME_LEN; i++)
            tx_bytes_due.push_back('{tx: f[i], last: (i == FRAME_LEN - 1)});
    endtask

    task automatic queue_reading(input t_request r);
        logic [15:0] v;
        v = reported_ppm(r);
        queue_frame(CMD_READ, v[15:8], v[7:0]);
    endtask

    // full command frame gathered
    task automatic decode_command(input t_request r);
        cmd_count = '0;
        if (cmd_buf[0] != START_BYTE || cmd_buf[8] != frame_checksum(cmd_buf) || fault_on)
            return;
        if (cmd_buf[1] == CMD_READ) begin
            queue_reading(r);
        end else if (cmd_buf[1] == ADDR_ONE) begin
            if (cmd_buf[2] == CMD_READ) begin
                queue_reading(r);
            end else if (cmd_buf[2] == CMD_SWITCH && cmd_buf[3] == SUB_QUERY) begin
                query_on = 1'b1;
                queue_frame(CMD_SWITCH, ADDR_ONE, ZERO_BYTE);
            end else if (cmd_buf[2] == CMD_SWITCH && cmd_buf[3] == SUB_ACTIVE) begin
                query_on = 1'b0;
                queue_frame(CMD_SWITCH, ADDR_ONE, ZERO_BYTE);
            end else if (cmd_buf[2] == CMD_ZERO_CAL) begin
                queue_frame(CMD_ZERO_CAL, ADDR_ONE, ZERO_BYTE);
            end else if (cmd_buf[2] == CMD_SPAN_CAL) begin
                queue_frame(CMD_SPAN_CAL, ADDR_ONE, ZERO_BYTE);
            end
        end
    endtask

    task automatic predict_response(input t_request r);
        case (r.req)
            REQ_RX_BYTE: begin
                // a stray byte outside a frame is ignored
                if (cmd_count != 0 || r.rx == START_BYTE) begin
                    if (cmd_count >= FRAME_LEN) begin
                        cmd_count = '0;
                    end else begin
                        cmd_buf[cmd_count] = r.rx;
                        cmd_count++;
                        if (cmd_count >= FRAME_LEN) decode_command(r);
                    end
                end
            end
            REQ_UPLOAD: begin
                if (!fault_on && !query_on) queue_reading(r);
            end
            REQ_TIMEOUT: begin
                if (cmd_count > 0 && cmd_count < FRAME_LEN) cmd_count = '0;
            end
            default: begin
                tx_busy = 1'b0;
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // response side: ready pattern with an optional long hold-off
    // ------------------------------------------------------------------------
    initial begin
        int hold_left;
        hold_left    = 0;
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_go) hold_left = HOLD_CYCLES;
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // compare each response beat against the oldest queued byte
    always @(posedge i_clk) begin
        t_tx_beat due;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            tx_beats++;
            if (tx_bytes_due.size() == 0) begin
                $error("unexpected response beat: tx_byte %02h last_byte %0b",
                       out_if.tx_byte, out_if.last_byte);
                errors++;
            end else begin
                due = tx_bytes_due.pop_front();
                if (out_if.tx_byte !== due.tx) begin
                    $error("tx_byte mismatch: expected %02h, actual %02h",
                           due.tx, out_if.tx_byte);
                    errors++;
                end
                if (out_if.last_byte !== due.last) begin
                    $error("last_byte mismatch: expected %0b, actual %0b",
                           due.last, out_if.last_byte);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------
    function automatic t_request make_req(input t_req kind, input logic [7:0] rx,
                                          input logic signed [15:0] ppm,
                                          input logic inv, input logic warm);
        t_request r;
        r.req  = kind;
        r.rx   = rx;
        r.ppm  = ppm;
        r.inv  = inv;
        r.warm = warm;
        return r;
    endfunction

    // random reading fields, mostly around the clamp range
    function automatic t_request rand_reading(input t_req kind, input logic [7:0] rx);
        t_request r;
        r.req = kind;
        r.rx  = rx;
        case ($urandom_range(3))
            0:       r.ppm = 16'($urandom);
            3:       r.ppm = 16'($urandom_range(100));
            default: r.ppm = 16'(int'($urandom_range(140)) - 20);
        endcase
        r.inv  = ($urandom_range(4) == 0);
        r.warm = ($urandom_range(4) == 0);
        return r;
    endfunction

    // one request beat; valid stays high on return, the caller lowers it
    task automatic send_request(input t_request r);
        if ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            do begin
                @(posedge i_clk);
            end while ($urandom_range(99) < send_idle_pct);
        end
        in_if.valid             <= 1'b1;
        in_if.req_type          <= r.req;
        in_if.rx_byte           <= r.rx;
        in_if.concentration_ppm <= r.ppm;
        in_if.reading_invalid   <= r.inv;
        in_if.warming_up        <= r.warm;
        do begin
            @(posedge i_clk);
        end while (!in_if.ready);
        req_beats++;
        predict_response(r);
    endtask

    task automatic send_kind(input t_req kind);
        send_request(rand_reading(kind, 8'($urandom)));
    endtask

    task automatic drive_frame(input t_frame f);
        for (int i = 0; i < FRAME_LEN; i++)
            send_request(rand_reading(REQ_RX_BYTE, f[i]));
    endtask

    function automatic t_frame build_frame(input logic [7:0] b1, input logic [7:0] b2,
                                           input logic [7:0] b3, input logic bad_sum);
        t_frame f;
        f[0] = START_BYTE;
        f[1] = b1;
        f[2] = b2;
        f[3] = b3;
        for (int i = 4; i <= 7; i++) f[i] = 8'($urandom);
        f[8] = frame_checksum(f);
        if (bad_sum) f[8] ^= 8'($urandom_range(255, 1));
        return f;
    endfunction

    // stop offering, wait for every queued byte, then let the block settle
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (tx_bytes_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_fault(input logic value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        fault_on = value;
        i_cfg_we <= 1'b0;
    endtask

    // well-formed frame with a random command; a few carry a bad checksum
    task automatic send_random_command();
        logic [7:0] b2;
        logic [7:0] b3;
        logic       bad;
        t_frame     f;
        b2  = 8'($urandom);
        b3  = 8'($urandom);
        bad = ($urandom_range(9) == 0);
        // flush any partial frame so this one lines up
        if (cmd_count != 0) send_kind(REQ_TIMEOUT);
        case ($urandom_range(7))
            0:       f = build_frame(CMD_READ, b2, b3, bad);
            1:       f = build_frame(ADDR_ONE, CMD_READ, b3, bad);
            2:       f = build_frame(ADDR_ONE, CMD_SWITCH, SUB_QUERY, bad);
            3:       f = build_frame(ADDR_ONE, CMD_SWITCH, SUB_ACTIVE, bad);
            4:       f = build_frame(ADDR_ONE, CMD_ZERO_CAL, b3, bad);
            5:       f = build_frame(ADDR_ONE, CMD_SPAN_CAL, b3, bad);
            6:       f = build_frame(ADDR_ONE, CMD_SWITCH, b3, bad);
            default: f = build_frame(8'($urandom), b2, b3, bad);
        endcase
        drive_frame(f);
    endtask

    task automatic run_random_traffic(input int budget);
        int first_beat;
        int pick;
        int extra;
        first_beat = req_beats;
        while (req_beats - first_beat < budget) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                send_random_command();
                if ($urandom_range(9) < 7) send_kind(REQ_TX_DONE);
            end else if (pick < 65) begin
                send_kind(REQ_UPLOAD);
                if ($urandom_range(9) < 7) send_kind(REQ_TX_DONE);
            end else if (pick < 75) begin
                send_kind(REQ_TX_DONE);
            end else if (pick < 85) begin
                // broken frame cut off by a timeout
                send_request(rand_reading(REQ_RX_BYTE, START_BYTE));
                extra = $urandom_range(7);
                repeat (extra) send_request(rand_reading(REQ_RX_BYTE, 8'($urandom)));
                send_kind(REQ_TIMEOUT);
            end else if (pick < 92) begin
                send_kind(REQ_TIMEOUT);
            end else begin
                send_request(rand_reading(REQ_RX_BYTE, 8'($urandom)));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // upload ticks: clamp extremes, warmup, invalid, busy transmitter
    task automatic test_upload_readings();
        send_request(make_req(REQ_UPLOAD, 8'hFF, 16'sh8000, 1'b0, 1'b0));
        send_request(make_req(REQ_TX_DONE, 8'h00, 16'sh0000, 1'b0, 1'b0));
        send_request(make_req(REQ_UPLOAD, 8'h00, 16'sh7FFF, 1'b0, 1'b0));
        send_request(make_req(REQ_TX_DONE, 8'hFF, 16'shFFFF, 1'b1, 1'b1));
        send_request(make_req(REQ_UPLOAD, 8'hA5, 16'sd100, 1'b1, 1'b0));
        send_request(make_req(REQ_TX_DONE, 8'h5A, 16'sd0, 1'b0, 1'b0));
        send_request(make_req(REQ_UPLOAD, 8'h3C, 16'sd50, 1'b0, 1'b1));
        // transmitter still busy: no frame
        send_request(make_req(REQ_UPLOAD, 8'hC3, 16'sd77, 1'b0, 1'b0));
        send_request(make_req(REQ_TX_DONE, 8'h00, 16'sd0, 1'b0, 1'b0));
        send_request(make_req(REQ_UPLOAD, 8'h00, 16'sd0, 1'b0, 1'b0));
        send_request(make_req(REQ_TX_DONE, 8'h00, 16'sd0, 1'b0, 1'b0));
    endtask

    // stray bytes outside a frame, timeouts idle and mid-frame
    task automatic test_stray_and_timeout();
        send_request(make_req(REQ_RX_BYTE, 8'h00, 16'sd0, 1'b0, 1'b0));
        send_request(make_req(REQ_RX_BYTE, 8'h7F, 16'sd0, 1'b0, 1'b0));
        send_request(make_req(REQ_TIMEOUT, 8'h00, 16'sd0, 1'b0, 1'b0));
        send_request(make_req(REQ_RX_BYTE, START_BYTE, 16'sd0, 1'b0, 1'b0));
        send_request(make_req(REQ_RX_BYTE, ADDR_ONE, 16'sd0, 1'b0, 1'b0));
        send_request(make_req(REQ_TIMEOUT, 8'h00, 16'sd0, 1'b0, 1'b0));
        send_request(make_req(REQ_RX_BYTE, CMD_READ, 16'sd0, 1'b0, 1'b0));
    endtask

    // one addressed read command
    task automatic test_command_frame();
        drive_frame(build_frame(ADDR_ONE, CMD_READ, ZERO_BYTE, 1'b0));
        send_request(make_req(REQ_TX_DONE, 8'h00, 16'sd0, 1'b0, 1'b0));
    endtask

    // fault set: commands dropped, uploads suppressed; then cleared again
    task automatic test_fault_register();
        wait_drained();
        write_fault(1'b1);
        run_random_traffic(30);
        send_kind(REQ_UPLOAD);
        wait_drained();
        write_fault(1'b0);
    endtask

    task automatic test_random_traffic();
        send_idle_pct = 10;
        recv_idle_pct <= 46;
        run_random_traffic(55);
        send_idle_pct = 46;
        recv_idle_pct <= 10;
        run_random_traffic(55);
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        run_random_traffic(55);
        wait_drained();
    endtask

    // receiver holds off while uploads keep coming, so the block backs up
    task automatic test_backpressure();
        send_idle_pct = 0;
        hold_go <= 1'b1;
        @(posedge i_clk);
        hold_go <= 1'b0;
        // clear any partial frame so the mode switch lines up
        send_kind(REQ_TIMEOUT);
        send_kind(REQ_TX_DONE);
        drive_frame(build_frame(ADDR_ONE, CMD_SWITCH, SUB_ACTIVE, 1'b0));
        send_kind(REQ_TX_DONE);
        repeat (8) begin
            send_kind(REQ_UPLOAD);
            send_kind(REQ_TX_DONE);
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n                 = 1'b0;
        i_cfg_we                = 1'b0;
        i_cfg_wdata             = 1'b0;
        in_if.valid             = 1'b0;
        in_if.req_type          = REQ_RX_BYTE;
        in_if.rx_byte           = 8'h00;
        in_if.concentration_ppm = 16'sd0;
        in_if.reading_invalid   = 1'b0;
        in_if.warming_up        = 1'b0;
        fault_on                = 1'b0;
        cmd_buf                 = '0;
        cmd_count               = '0;
        query_on                = 1'b0;
        tx_busy                 = 1'b0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 10;
        recv_idle_pct <= 46;
        test_upload_readings();
        test_stray_and_timeout();
        test_command_frame();
        test_fault_register();
        test_random_traffic();
        test_backpressure();
        wait_drained();

        if (tx_bytes_due.size() != 0) begin
            $error("%0d response bytes never arrived", tx_bytes_due.size());
            errors += tx_bytes_due.size();
        end
        $display("Run covered %0d request beats and %0d response beats: uploads,",
                 req_beats, tx_beats);
        $display("command frames, fault drops, timeouts and a long receiver stall.");
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/gsr_pkg.sv
design/gsr_in_if.sv
design/gsr_out_if.sv
design/gsr_resp_fifo.sv
design/gsr_front.sv
design/gsr_back.sv
design/gas_sensor_uart_frame_responder.sv
tb/sv/gas_sensor_uart_frame_responder_test.sv
